// File: rtl/core/charge_plateau_gain_calibrator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the charge plateau gain calibrator
// Shared macros for writing concurrent checks in one house style.
// ----------------------------------------------------------------------------
`ifndef CHARGE_PLATEAU_GAIN_CALIBRATOR_MACROS_SVH
`define CHARGE_PLATEAU_GAIN_CALIBRATOR_MACROS_SVH

// Check a property on every clock edge outside of reset
`define CPGC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define CPGC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/cpgc_pkg.sv
// ----------------------------------------------------------------------------
// cpgc_pkg
// Types, constants and register codes shared by the gain calibrator files.
// ----------------------------------------------------------------------------
package cpgc_pkg;

    // Widths of the fixed fields
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int WIDE_W          = CFG_W + 1;
    localparam int COUNT_W         = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    // Gain scale and the dividend it produces from a 16-bit cv level
    localparam int GAIN_SCALE  = 1000;
    localparam int DIVIDEND_W  = 26;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RISE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FALL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BAND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SAMPLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CV      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAL_MIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAL_MAX = 3'd6;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_RISE    = 16'd100;
    localparam logic [CFG_W-1:0] RST_FALL    = 16'd100;
    localparam logic [CFG_W-1:0] RST_BAND    = 16'd10;
    localparam logic [CFG_W-1:0] RST_SAMPLES = 16'd60;
    localparam logic [CFG_W-1:0] RST_CV      = 16'd4200;
    localparam logic [CFG_W-1:0] RST_CAL_MIN = 16'd850;
    localparam logic [CFG_W-1:0] RST_CAL_MAX = 16'd1150;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // Divider control and status
    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: rtl/core/cpgc_div.sv
// ----------------------------------------------------------------------------
// cpgc_div
// Restoring unsigned divider, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module cpgc_div #(
    parameter int DIVIDEND_W = cpgc_pkg::DIVIDEND_W,
    parameter int DIVISOR_W  = cpgc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cpgc_pkg::div_req_t     req,
    input  logic [DIVIDEND_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]   divisor,
    output cpgc_pkg::div_stat_t    stat,
    output logic [DIVIDEND_W-1:0]  quotient
);
    import cpgc_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg,  quo_next;
    logic [DIVISOR_W-1:0]  rem_reg,  rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg,  dvs_next;
    logic [CNT_W-1:0]      cnt_reg,  cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // Shift the next dividend bit into the partial remainder and trial-subtract
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// File: rtl/core/charge_plateau_gain_calibrator.sv
// An accepted sample passes through the EVAL and DONE states before its result
// is offered; a sample that anchors a session also passes through DIV, where the
// bit-serial divider runs its 26 steps. A new sample is taken only once the last
// result has entered the output register, so a stalled result holds it off.
// Reset (aresetn, synchronous, active low) restores the configuration defaults
// and clears all tracking state; there is no clearing pass.
// ----------------------------------------------------------------------------
// charge_plateau_gain_calibrator
// Tracks a battery charge session and learns a voltage gain at its plateau.
// ----------------------------------------------------------------------------
module charge_plateau_gain_calibrator #(
    parameter int SAMPLE_BITS = cpgc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [cpgc_pkg::CFG_IDX_W-1:0] cfg_wr_idx,
    input  logic [cpgc_pkg::CFG_W-1:0]     cfg_wr_data,
    // sample input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [15:0]                    s_sample_mv,
    // gain result
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_gain_valid,
    output logic [15:0]                    m_gain_permille
);
    import cpgc_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] rise_reg, fall_reg, band_reg, samples_reg;
    logic [CFG_W-1:0] cv_reg, cal_min_reg, cal_max_reg;

    // Tracking state
    logic                   primed_reg,   primed_next;
    logic                   charging_reg, charging_next;
    logic                   anchored_reg, anchored_next;
    logic [SAMPLE_BITS-1:0] min_reg,      min_next;
    logic [SAMPLE_BITS-1:0] peak_reg,     peak_next;
    logic [SAMPLE_BITS-1:0] plat_reg,     plat_next;
    logic [COUNT_W-1:0]     flat_reg,     flat_next;

    // Sequencer and result staging
    state_t                 state_reg, state_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   res_gv_reg,   res_gv_next;
    logic [15:0]            res_gain_reg, res_gain_next;
    logic                   m_valid_reg,  m_valid_next;
    logic                   m_gv_reg;
    logic [15:0]            m_gain_reg;

    // Evaluation terms
    logic [SAMPLE_BITS-1:0] min1, peak1, peak2, diff;
    logic [WIDE_W-1:0]      s_w;
    logic                   rise_hit, charging1, fall_hit, out_band, anchor_hit;
    logic [COUNT_W-1:0]     flat_inc;

    // Divider
    div_req_t              div_req;
    div_stat_t             div_stat;
    logic [DIVIDEND_W-1:0] product, quotient;
    logic                  gain_ok;

    // Write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg    <= RST_RISE;
            fall_reg    <= RST_FALL;
            band_reg    <= RST_BAND;
            samples_reg <= RST_SAMPLES;
            cv_reg      <= RST_CV;
            cal_min_reg <= RST_CAL_MIN;
            cal_max_reg <= RST_CAL_MAX;
        end else if (cfg_wr_en) begin
            case (cfg_wr_idx)
                CFG_IDX_RISE:    rise_reg    <= cfg_wr_data;
                CFG_IDX_FALL:    fall_reg    <= cfg_wr_data;
                CFG_IDX_BAND:    band_reg    <= cfg_wr_data;
                CFG_IDX_SAMPLES: samples_reg <= cfg_wr_data;
                CFG_IDX_CV:      cv_reg      <= cfg_wr_data;
                CFG_IDX_CAL_MIN: cal_min_reg <= cfg_wr_data;
                CFG_IDX_CAL_MAX: cal_max_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Track minimum, peak and plateau for the held sample
    always_comb begin
        s_w       = WIDE_W'(sample_reg);
        min1      = (sample_reg < min_reg)  ? sample_reg : min_reg;
        peak1     = (sample_reg > peak_reg) ? sample_reg : peak_reg;
        rise_hit  = !charging_reg && (s_w >= WIDE_W'(min1) + WIDE_W'(rise_reg));
        charging1 = charging_reg || rise_hit;
        peak2     = rise_hit ? sample_reg : peak1;
        fall_hit  = charging1 && (s_w + WIDE_W'(fall_reg) <= WIDE_W'(peak2));
        diff      = (sample_reg >= plat_reg) ? (sample_reg - plat_reg)
                                             : (plat_reg - sample_reg);
        out_band  = CFG_W'(diff) > band_reg;
        flat_inc  = (flat_reg == COUNT_MAX) ? flat_reg : flat_reg + 1'b1;
        anchor_hit = charging1 && !anchored_reg && (flat_inc >= samples_reg);
    end

    // Scale the constant-voltage level for the division
    assign product = DIVIDEND_W'(cv_reg) * DIVIDEND_W'(GAIN_SCALE);

    // Refuse gains at or beyond the limits
    assign gain_ok = !(quotient <= DIVIDEND_W'(cal_min_reg)) &&
                     !(quotient >= DIVIDEND_W'(cal_max_reg));

    // Sequence one sample through evaluation, optional division and output
    always_comb begin
        state_next    = state_reg;
        primed_next   = primed_reg;
        charging_next = charging_reg;
        anchored_next = anchored_reg;
        min_next      = min_reg;
        peak_next     = peak_reg;
        plat_next     = plat_reg;
        flat_next     = flat_reg;
        res_gv_next   = res_gv_reg;
        res_gain_next = res_gain_reg;
        m_valid_next  = m_valid_reg;
        div_req.start = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                res_gv_next   = 1'b0;
                res_gain_next = '0;
                state_next    = ST_DONE;
                if (!primed_reg) begin
                    primed_next = 1'b1;
                    min_next    = sample_reg;
                    peak_next   = sample_reg;
                    plat_next   = sample_reg;
                    flat_next   = '0;
                end else if (fall_hit) begin
                    // end the session and re-center on this sample
                    plat_next     = sample_reg;
                    flat_next     = '0;
                    charging_next = 1'b0;
                    anchored_next = 1'b0;
                    min_next      = sample_reg;
                    peak_next     = sample_reg;
                end else begin
                    min_next      = min1;
                    peak_next     = peak2;
                    charging_next = charging1;
                    if (out_band) begin
                        plat_next = sample_reg;
                        flat_next = '0;
                    end else begin
                        flat_next = flat_inc;
                        if (anchor_hit) begin
                            anchored_next = 1'b1;
                            if (sample_reg != '0) begin
                                div_req.start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    res_gv_next   = gain_ok;
                    res_gain_next = gain_ok ? quotient[15:0] : 16'd0;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                // hand the result over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            primed_reg   <= 1'b0;
            charging_reg <= 1'b0;
            anchored_reg <= 1'b0;
            min_reg      <= '0;
            peak_reg     <= '0;
            plat_reg     <= '0;
            flat_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            primed_reg   <= primed_next;
            charging_reg <= charging_next;
            anchored_reg <= anchored_next;
            min_reg      <= min_next;
            peak_reg     <= peak_next;
            plat_reg     <= plat_next;
            flat_reg     <= flat_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_sample_mv[SAMPLE_BITS-1:0];
        end
        res_gv_reg   <= res_gv_next;
        res_gain_reg <= res_gain_next;
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_gv_reg   <= res_gv_reg;
            m_gain_reg <= res_gain_reg;
        end
    end

    cpgc_div #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (product),
        .divisor  (sample_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_gain_valid    = m_gv_reg;
    assign m_gain_permille = m_gain_reg;

endmodule

// File: rtl/core/cpgc_checker.sv
// ----------------------------------------------------------------------------
// cpgc_checker
// Port-level checks for the gain calibrator, bound to the top level.
// ----------------------------------------------------------------------------
`include "charge_plateau_gain_calibrator_macros.svh"

module cpgc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_gain_valid,
    input logic [15:0] m_gain_permille
);
    import cpgc_pkg::*;

    // Reset empties the output register
    `CPGC_ASSERT_ALWAYS(a_rst_out_empty, aclk, !aresetn |=> !m_valid, "output valid after reset")

    // A stalled result keeps its payload
    `CPGC_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_gain_valid) && $stable(m_gain_permille), "stalled result changed")

    // A refused gain reads as zero
    `CPGC_ASSERT(a_refused_zero, aclk, aresetn, m_valid && !m_gain_valid |-> m_gain_permille == 16'd0, "refused gain not zero")

    // One sample at a time: an accepted transaction drops ready
    `CPGC_ASSERT(a_one_in_flight, aclk, aresetn, s_valid && s_ready |=> !s_ready, "ready held after accept")

endmodule

bind charge_plateau_gain_calibrator cpgc_checker u_cpgc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_gain_valid    (m_gain_valid),
    .m_gain_permille (m_gain_permille)
);
